// File: design/assert_macros.svh
// Assertion macros for the design files that carry checks.
// No dependencies; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/gsr_pkg.sv
// Package for the gas sensor ratio converter: widths, stage indexes and
// the fixed-point constants of the six gas maps. No dependencies.
package gsr_pkg;

    localparam int RATIO_FRAC_BITS = 16;

    localparam int RAW_W  = 16;
    localparam int NUM_W  = RAW_W + 1;
    localparam int RW     = RATIO_FRAC_BITS + 8;
    localparam int QW     = RATIO_FRAC_BITS + 9;
    localparam int AW     = RATIO_FRAC_BITS + RAW_W;
    localparam int NCH    = 2;
    localparam int NGAS   = 6;
    localparam int MW     = 24;
    localparam int MH     = 12;
    localparam int PW     = RW + MH;
    localparam int NW     = RW + MW;
    localparam int XW     = NW - RATIO_FRAC_BITS;
    localparam int VW     = 15;

    // Division by a lane constant through a reciprocal product. The scaled
    // value is below 2^XQW whenever the lane is not clamped, and the shift is
    // large enough that the product floors exactly over that range.
    localparam int XQW    = 25;
    localparam int RCP_SH = 34;
    localparam int RCP_W  = 31;
    localparam int QPW    = XQW + RCP_W;

    localparam int CO_W   = 14;
    localparam int CH4_W  = 15;
    localparam int ETOH_W = 13;
    localparam int H2_W   = 14;
    localparam int NH3_W  = 13;
    localparam int NO2_W  = 10;

    localparam int CH_RED = 0;
    localparam int CH_OX  = 1;

    localparam int GAS_CO   = 0;
    localparam int GAS_CH4  = 1;
    localparam int GAS_ETOH = 2;
    localparam int GAS_H2   = 3;
    localparam int GAS_NH3  = 4;
    localparam int GAS_NO2  = 5;

    // Pipeline stage indexes.
    localparam int S_PREP = 1;
    localparam int S_FIX  = QW + 2;
    localparam int S_LANE = QW + 3;
    localparam int S_PROD = QW + 4;
    localparam int S_SUM  = QW + 5;
    localparam int S_RCP  = S_SUM + 1;
    localparam int S_OUT  = S_RCP + 1;
    localparam int NS     = S_OUT + 1;
    localparam int ZD     = S_RCP - S_LANE;

    typedef enum logic [1:0] {
        ST_MEAS  = 2'd0,
        ST_CAL   = 2'd1,
        ST_NOREF = 2'd2
    } t_status;

    localparam longint P1 = longint'(1) << RATIO_FRAC_BITS;

    // Decimal constants rounded half up into the ratio format.
    localparam longint K_CO    = (425 * P1 * 2 + 1000) / 2000;
    localparam longint K_CH4   = (786 * P1 * 2 + 1000) / 2000;
    localparam longint K_ETOH  = (306 * P1 * 2 + 1000) / 2000;
    localparam longint K_H2    = (279 * P1 * 2 + 1000) / 2000;
    localparam longint K_NH3   = (8 * P1 * 2 + 10) / 20;
    localparam longint K_NO2_M = (11 * P1 * 2 + 10) / 20;
    localparam longint K_NO2_O = (45 * P1 * 2 + 1000) / 2000;

    localparam longint GAS_K    [NGAS] = '{K_CO, K_CH4, K_ETOH, K_H2, K_NH3, K_NO2_O};
    localparam longint GAS_MUL  [NGAS] = '{10000000, 1000000, 1000000, 1000000, 100000, 10000};
    localparam longint GAS_DEN  [NGAS] = '{405, 23, 57, 26, 15, 613};
    localparam longint GAS_LOW  [NGAS] = '{10, 1000, 100, 10, 10, 10};
    localparam longint GAS_HIGH [NGAS] = '{10000, 25000, 5000, 10000, 5000, 1000};

    // Reciprocals of the lane divisors, rounded up.
    localparam longint GAS_RCP [NGAS] = '{
        ((longint'(1) << RCP_SH) + 405 - 1) / 405,
        ((longint'(1) << RCP_SH) + 23 - 1) / 23,
        ((longint'(1) << RCP_SH) + 57 - 1) / 57,
        ((longint'(1) << RCP_SH) + 26 - 1) / 26,
        ((longint'(1) << RCP_SH) + 15 - 1) / 15,
        ((longint'(1) << RCP_SH) + 613 - 1) / 613
    };

    // Smallest difference whose scaled value exceeds the upper clamp.
    localparam longint GAS_DH [NGAS] = '{
        ((10000 + 1) * 405 * P1 + 10000000 - 1) / 10000000,
        ((25000 + 1) * 23 * P1 + 1000000 - 1) / 1000000,
        ((5000 + 1) * 57 * P1 + 1000000 - 1) / 1000000,
        ((10000 + 1) * 26 * P1 + 1000000 - 1) / 1000000,
        ((5000 + 1) * 15 * P1 + 100000 - 1) / 100000,
        ((1000 + 1) * 613 * P1 + 10000 - 1) / 10000
    };

endpackage

// File: design/gsr_if.sv
// Valid/ready channel interfaces for the sensor reading and the result item.
// Depends on gsr_pkg for the field widths.
interface gsr_in_if import gsr_pkg::*;;
    logic             valid;
    logic             ready;
    logic             command;
    logic [RAW_W-1:0] ox_raw;
    logic [RAW_W-1:0] red_raw;
    logic [RAW_W-1:0] supply_raw;
    modport source (output valid, command, ox_raw, red_raw, supply_raw, input ready);
    modport sink   (input valid, command, ox_raw, red_raw, supply_raw, output ready);
endinterface

interface gsr_out_if import gsr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [CO_W-1:0]   co_tenth_ppm;
    logic [CH4_W-1:0]  methane_ppm;
    logic [ETOH_W-1:0] ethanol_tenth_ppm;
    logic [H2_W-1:0]   hydrogen_tenth_ppm;
    logic [NH3_W-1:0]  ammonia_tenth_ppm;
    logic [NO2_W-1:0]  no2_hundredth_ppm;
    modport source (output valid, status, co_tenth_ppm, methane_ppm, ethanol_tenth_ppm,
                    hydrogen_tenth_ppm, ammonia_tenth_ppm, no2_hundredth_ppm, input ready);
    modport sink   (input valid, status, co_tenth_ppm, methane_ppm, ethanol_tenth_ppm,
                    hydrogen_tenth_ppm, ammonia_tenth_ppm, no2_hundredth_ppm, output ready);
endinterface

// File: design/gas_sensor_ratio_to_ppm_top.sv
// Top level of the gas sensor ratio converter: one fully pipelined datapath.
// Depends on gsr_pkg, the channel interfaces in gsr_if.sv and assert_macros.svh.

// The block takes one item per clock unless the output stalls, a raw oxidizing,
// reducing and supply reading with a command, and returns one result item per
// input item, in order. A calibrate item stores the references (supply
// minus each raw reading) and returns status 1 with zero concentrations; the
// next item already sees the new references. A measure item with either
// reference zero returns status 2. Otherwise both Rs/R0 ratios are formed in
// signed fixed point by a 25-stage restoring divider (one quotient bit per
// stage per channel), and six gas lanes each run a split multiplier followed by
// a multiplication with the reciprocal of its divisor. The whole pipeline
// advances together and holds while a finished result waits at the output, so
// throughput is one item per cycle whenever the consumer takes results.
module gas_sensor_ratio_to_ppm_top
    import gsr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    gsr_in_if.sink        i_in,
    gsr_out_if.source     o_out
);

`include "assert_macros.svh"

    logic w_en;

    // Control line: valid bit and status travel with every item.
    logic    r_vld [0:NS-1];
    t_status r_sts [0:NS-1];

    logic [RAW_W-1:0] r_ref [0:NCH-1];

    // Entry stage.
    logic signed [NUM_W-1:0] r_num  [0:NCH-1];
    logic signed [RAW_W-1:0] r_refv [0:NCH-1];

    // Ratio divider stages; index 0 is the preparation stage.
    logic [RAW_W-1:0] r_dm  [0:QW][0:NCH-1];
    logic [RAW_W-1:0] r_rem [0:QW][0:NCH-1];
    logic [QW-1:0]    r_dvd [0:QW][0:NCH-1];
    logic [QW-1:0]    r_quo [0:QW][0:NCH-1];
    logic             r_neg [0:QW][0:NCH-1];
    logic             r_ovf [0:QW][0:NCH-1];

    logic signed [RW-1:0] r_ratio [0:NCH-1];

    // Gas lanes.
    logic [RW-1:0]   r_d   [0:NGAS-1];
    logic            r_z   [0:ZD][0:NGAS-1];
    logic            r_cl  [0:ZD][0:NGAS-1];
    logic [PW-1:0]   r_plo [0:NGAS-1];
    logic [PW-1:0]   r_phi [0:NGAS-1];
    logic [XQW-1:0]  r_cx  [0:NGAS-1];
    logic [QPW-1:0]  r_qp  [0:NGAS-1];

    logic [VW-1:0]   r_gas [0:NGAS-1];

    // Next-value nets.
    t_status                 n_sts;
    logic [RAW_W-1:0]        n_cal [0:NCH-1];
    logic signed [NUM_W-1:0] n_num [0:NCH-1];
    logic [RAW_W-1:0]        n_dm  [0:NCH-1];
    logic [RAW_W-1:0]        n_rem0 [0:NCH-1];
    logic [QW-1:0]           n_dvd0 [0:NCH-1];
    logic                    n_neg [0:NCH-1];
    logic                    n_ovf [0:NCH-1];
    logic signed [RW-1:0]    n_ratio [0:NCH-1];
    logic [RW-1:0]           n_d  [0:NGAS-1];
    logic                    n_z  [0:NGAS-1];
    logic                    n_cl [0:NGAS-1];
    logic [XQW-1:0]          n_cx0 [0:NGAS-1];
    logic [VW-1:0]           n_gas [0:NGAS-1];

    assign w_en       = !r_vld[NS-1] || o_out.ready;
    assign i_in.ready = w_en;

    // Entry: differences and status from the references held now.
    always_comb begin
        n_cal[CH_RED] = i_in.supply_raw - i_in.red_raw;
        n_cal[CH_OX]  = i_in.supply_raw - i_in.ox_raw;
        n_num[CH_RED] = $signed({1'b0, i_in.supply_raw}) - $signed({1'b0, i_in.red_raw});
        n_num[CH_OX]  = $signed({1'b0, i_in.supply_raw}) - $signed({1'b0, i_in.ox_raw});
        if (i_in.command) begin
            n_sts = ST_CAL;
        end else if (r_ref[CH_RED] == '0 || r_ref[CH_OX] == '0) begin
            n_sts = ST_NOREF;
        end else begin
            n_sts = ST_MEAS;
        end
    end

    // Preparation: magnitudes, result sign and an early overflow test.
    always_comb begin
        logic [NUM_W-1:0] mag;
        logic [AW-1:0]    amag;
        logic [AW-QW-1:0] top;
        for (int c = 0; c < NCH; c++) begin
            mag      = r_num[c][NUM_W-1] ? NUM_W'(-r_num[c]) : NUM_W'(r_num[c]);
            amag     = {mag[RAW_W-1:0], {RATIO_FRAC_BITS{1'b0}}};
            top      = amag[AW-1:QW];
            n_dm[c]  = r_refv[c][RAW_W-1] ? RAW_W'(-r_refv[c]) : RAW_W'(r_refv[c]);
            n_neg[c] = r_num[c][NUM_W-1] ^ r_refv[c][RAW_W-1];
            n_ovf[c] = RAW_W'(top) >= n_dm[c];
            n_rem0[c] = RAW_W'(top);
            n_dvd0[c] = amag[QW-1:0];
        end
    end

    // Floor correction for negative quotients and saturation.
    always_comb begin
        logic [QW-1:0] q;
        logic          rnz;
        logic          sat;
        for (int c = 0; c < NCH; c++) begin
            q   = r_quo[QW][c];
            rnz = r_rem[QW][c] != '0;
            if (!r_neg[QW][c]) begin
                sat = r_ovf[QW][c] || q > {2'b00, {(RW-1){1'b1}}};
                n_ratio[c] = sat ? $signed({1'b0, {(RW-1){1'b1}}}) : $signed(q[RW-1:0]);
            end else begin
                sat = r_ovf[QW][c] || q > {2'b01, {(RW-1){1'b0}}} ||
                      (q == {2'b01, {(RW-1){1'b0}}} && rnz);
                n_ratio[c] = sat ? $signed({1'b1, {(RW-1){1'b0}}}) :
                             $signed(-q[RW-1:0] - RW'(rnz));
            end
        end
    end

    // Lane setup: difference from the gas constant, zero and clamp decisions.
    always_comb begin
        logic signed [RW+1:0] re;
        logic signed [RW+1:0] k;
        logic signed [RW+1:0] diff;
        for (int l = 0; l < NGAS; l++) begin
            k = $signed((RW+2)'(GAS_K[l]));
            if (l == GAS_NO2) begin
                re      = $signed({{2{r_ratio[CH_OX][RW-1]}}, r_ratio[CH_OX]});
                n_z[l]  = re < $signed((RW+2)'(K_NO2_M));
                diff    = re - k;
            end else begin
                re      = $signed({{2{r_ratio[CH_RED][RW-1]}}, r_ratio[CH_RED]});
                n_z[l]  = re > k;
                diff    = k - re;
            end
            n_d[l]  = diff[RW-1:0];
            n_cl[l] = {1'b0, n_d[l]} >= (RW+1)'(GAS_DH[l]);
        end
    end

    // Product sum, then drop the fraction bits. Bits above the kept range
    // only matter for clamped lanes.
    always_comb begin
        logic [NW-1:0] n;
        logic [XW-1:0] x;
        for (int l = 0; l < NGAS; l++) begin
            n = NW'(r_plo[l]) + (NW'(r_phi[l]) << MH);
            x = n[NW-1:RATIO_FRAC_BITS];
            n_cx0[l] = x[XQW-1:0];
        end
    end

    // Zero decision, final threshold and clamp on the quotient from the reciprocal product.
    always_comb begin
        logic [VW-1:0] q;
        for (int l = 0; l < NGAS; l++) begin
            q = r_qp[l][RCP_SH +: VW];
            if (r_z[ZD][l]) begin
                n_gas[l] = '0;
            end else if (r_cl[ZD][l]) begin
                n_gas[l] = VW'(GAS_HIGH[l]);
            end else if (q < VW'(GAS_LOW[l])) begin
                n_gas[l] = '0;
            end else begin
                n_gas[l] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [RAW_W:0]   t;
        logic [MW-1:0]    mul;
        logic [RCP_W-1:0] rcp;
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_ref[CH_RED] <= '0;
            r_ref[CH_OX]  <= '0;
        end else if (w_en) begin
            r_vld[0] <= i_in.valid;
            r_sts[0] <= n_sts;
            for (int s = 1; s < NS; s++) begin
                r_vld[s] <= r_vld[s-1];
                r_sts[s] <= r_sts[s-1];
            end
            if (i_in.valid && i_in.command) begin
                r_ref[CH_RED] <= n_cal[CH_RED];
                r_ref[CH_OX]  <= n_cal[CH_OX];
            end
            for (int c = 0; c < NCH; c++) begin
                r_num[c]    <= n_num[c];
                r_refv[c]   <= $signed(r_ref[c]);
                r_dm[0][c]  <= n_dm[c];
                r_rem[0][c] <= n_rem0[c];
                r_dvd[0][c] <= n_dvd0[c];
                r_quo[0][c] <= '0;
                r_neg[0][c] <= n_neg[c];
                r_ovf[0][c] <= n_ovf[c];
                // One quotient bit per stage.
                for (int j = 0; j < QW; j++) begin
                    t = {r_rem[j][c], r_dvd[j][c][QW-1]};
                    if (t >= {1'b0, r_dm[j][c]}) begin
                        r_rem[j+1][c] <= RAW_W'(t - {1'b0, r_dm[j][c]});
                        r_quo[j+1][c] <= {r_quo[j][c][QW-2:0], 1'b1};
                    end else begin
                        r_rem[j+1][c] <= t[RAW_W-1:0];
                        r_quo[j+1][c] <= {r_quo[j][c][QW-2:0], 1'b0};
                    end
                    r_dvd[j+1][c] <= r_dvd[j][c] << 1;
                    r_dm[j+1][c]  <= r_dm[j][c];
                    r_neg[j+1][c] <= r_neg[j][c];
                    r_ovf[j+1][c] <= r_ovf[j][c];
                end
                r_ratio[c] <= n_ratio[c];
            end
            for (int l = 0; l < NGAS; l++) begin
                mul = MW'(GAS_MUL[l]);
                rcp = RCP_W'(GAS_RCP[l]);
                r_d[l]     <= n_d[l];
                r_z[0][l]  <= n_z[l];
                r_cl[0][l] <= n_cl[l];
                r_plo[l]   <= PW'(r_d[l]) * PW'(mul[MH-1:0]);
                r_phi[l]   <= PW'(r_d[l]) * PW'(mul[MW-1:MH]);
                for (int k = 0; k < ZD; k++) begin
                    r_z[k+1][l]  <= r_z[k][l];
                    r_cl[k+1][l] <= r_cl[k][l];
                end
                r_cx[l]  <= n_cx0[l];
                r_qp[l]  <= QPW'(r_cx[l]) * QPW'(rcp);
                r_gas[l] <= n_gas[l];
            end
        end
    end

    // Results of calibrate and unreferenced items carry zero concentrations.
    assign o_out.valid              = r_vld[NS-1];
    assign o_out.status             = r_sts[NS-1];
    assign o_out.co_tenth_ppm       = (r_sts[NS-1] == ST_MEAS) ? r_gas[GAS_CO][CO_W-1:0] : '0;
    assign o_out.methane_ppm        = (r_sts[NS-1] == ST_MEAS) ? r_gas[GAS_CH4][CH4_W-1:0] : '0;
    assign o_out.ethanol_tenth_ppm  = (r_sts[NS-1] == ST_MEAS) ?
                                      r_gas[GAS_ETOH][ETOH_W-1:0] : '0;
    assign o_out.hydrogen_tenth_ppm = (r_sts[NS-1] == ST_MEAS) ? r_gas[GAS_H2][H2_W-1:0] : '0;
    assign o_out.ammonia_tenth_ppm  = (r_sts[NS-1] == ST_MEAS) ? r_gas[GAS_NH3][NH3_W-1:0] : '0;
    assign o_out.no2_hundredth_ppm  = (r_sts[NS-1] == ST_MEAS) ? r_gas[GAS_NO2][NO2_W-1:0] : '0;

    `ASSERT_NXT(a_cal_ref, i_clk, i_rst_n, i_in.valid && i_in.ready && i_in.command,
        r_ref[CH_OX] == $past(n_cal[CH_OX]) && r_ref[CH_RED] == $past(n_cal[CH_RED]),
        "calibrate item did not load references")
    `ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready,
        o_out.valid && $stable(r_vld[0]) && $stable(r_sts[NS-1]),
        "pipeline moved while output stalled")
    `ASSERT_IMP(a_clamp, i_clk, i_rst_n, o_out.valid,
        o_out.co_tenth_ppm <= 14'd10000 && o_out.methane_ppm <= 15'd25000 &&
        o_out.no2_hundredth_ppm <= 10'd1000,
        "concentration above clamp")
    `ASSERT_IMP(a_status, i_clk, i_rst_n, o_out.valid, o_out.status != 2'd3,
        "undefined status code")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for gas_sensor_ratio_to_ppm_top: drives sensor readings
// and checks every result item against an in-bench model of the ppm conversion.
// Depends on gsr_pkg, the channel interfaces in gsr_if.sv and the block itself.
`timescale 1ns / 100ps

module tb_top;
    import gsr_pkg::*;

    localparam int N_RANDOM   = 1530;
    localparam int STALL_MAX  = 5000;
    localparam int DRAIN_WAIT = 60;
    localparam int HOLD_LEN   = 300;
    localparam bit CMD_MEASURE   = 1'b0;
    localparam bit CMD_CALIBRATE = 1'b1;

    // One expected result item.
    typedef struct {
        logic [1:0]        status;
        logic [CO_W-1:0]   co;
        logic [CH4_W-1:0]  ch4;
        logic [ETOH_W-1:0] etoh;
        logic [H2_W-1:0]   h2;
        logic [NH3_W-1:0]  nh3;
        logic [NO2_W-1:0]  no2;
    } t_gas_reading;

    // Holds the calibration references and the queue of readings still owed
    // by the block, in order of acceptance.
    class t_ppm_scoreboard;
        t_gas_reading     owed_readings[$];
        logic [RAW_W-1:0] cal_ox;
        logic [RAW_W-1:0] cal_red;
        int               mismatches;

        function new();
            cal_ox = '0;
            cal_red = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return owed_readings.size();
        endfunction

        // Floored signed ratio num / ref, saturated to the signed Q8.16 format.
        function longint rs_ratio(longint num, logic [RAW_W-1:0] r);
            longint rf, a, q, hi, lo;
            rf = r[RAW_W-1] ? longint'(r) - 65536 : longint'(r);
            a  = num * P1;
            q  = a / rf;
            hi = (longint'(1) <<< (RATIO_FRAC_BITS + 7)) - 1;
            lo = -(longint'(1) <<< (RATIO_FRAC_BITS + 7));
            if ((a % rf) != 0 && ((a < 0) != (rf < 0)))
                q--;
            if (q > hi) q = hi;
            if (q < lo) q = lo;
            return q;
        endfunction

        function longint scaled(longint d, longint mul, longint den, longint low,
                                longint high);
            longint v;
            v = (d * mul) / (den * P1);
            if (v > high) return high;
            if (v < low) return 0;
            return v;
        endfunction

        // A reducing gas reads zero once the ratio is above its intercept.
        function longint reducing(longint r, longint k, longint mul, longint den,
                                  longint low, longint high);
            if (r > k) return 0;
            return scaled(k - r, mul, den, low, high);
        endfunction

        function void note_input(logic cmd, logic [RAW_W-1:0] ox, logic [RAW_W-1:0] red,
                                 logic [RAW_W-1:0] sup);
            t_gas_reading g;
            longint rr, ro;
            g = '{ST_MEAS, 0, 0, 0, 0, 0, 0};
            if (cmd == CMD_CALIBRATE) begin
                cal_ox  = sup - ox;
                cal_red = sup - red;
                g.status = ST_CAL;
            end else if (cal_ox == 0 || cal_red == 0) begin
                g.status = ST_NOREF;
            end else begin
                rr = rs_ratio(longint'(sup) - longint'(red), cal_red);
                ro = rs_ratio(longint'(sup) - longint'(ox), cal_ox);
                g.co   = CO_W'(reducing(rr, K_CO, 10000000, 405, 10, 10000));
                g.ch4  = CH4_W'(reducing(rr, K_CH4, 1000000, 23, 1000, 25000));
                g.etoh = ETOH_W'(reducing(rr, K_ETOH, 1000000, 57, 100, 5000));
                g.h2   = H2_W'(reducing(rr, K_H2, 1000000, 26, 10, 10000));
                g.nh3  = NH3_W'(reducing(rr, K_NH3, 100000, 15, 10, 5000));
                if (ro >= K_NO2_M)
                    g.no2 = NO2_W'(scaled(ro - K_NO2_O, 10000, 613, 10, 1000));
            end
            owed_readings.push_back(g);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(t_gas_reading got);
            t_gas_reading want;
            if (owed_readings.size() == 0) begin
                report("unexpected item, status", got.status, -1);
                return;
            end
            want = owed_readings.pop_front();
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.co !== want.co) report("co_tenth_ppm", got.co, want.co);
            if (got.ch4 !== want.ch4) report("methane_ppm", got.ch4, want.ch4);
            if (got.etoh !== want.etoh) report("ethanol_tenth_ppm", got.etoh, want.etoh);
            if (got.h2 !== want.h2) report("hydrogen_tenth_ppm", got.h2, want.h2);
            if (got.nh3 !== want.nh3) report("ammonia_tenth_ppm", got.nh3, want.nh3);
            if (got.no2 !== want.no2) report("no2_hundredth_ppm", got.no2, want.no2);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    gsr_in_if  in_ch ();
    gsr_out_if out_ch ();

    gas_sensor_ratio_to_ppm_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_ppm_scoreboard sb = new();

    // Idle pattern: 0 receiver idles more, 1 sender idles more, 2 nobody idles.
    int idle_phase = 0;
    bit hold_output = 1'b0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Acceptance on both channels is sampled at the rising edge, before any
    // nonblocking update of that edge lands.
    always @(posedge i_clk) begin
        t_gas_reading got;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_input(in_ch.command, in_ch.ox_raw, in_ch.red_raw, in_ch.supply_raw);
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                got.status = out_ch.status;
                got.co     = out_ch.co_tenth_ppm;
                got.ch4    = out_ch.methane_ppm;
                got.etoh   = out_ch.ethanol_tenth_ppm;
                got.h2     = out_ch.hydrogen_tenth_ppm;
                got.nh3    = out_ch.ammonia_tenth_ppm;
                got.no2    = out_ch.no2_hundredth_ppm;
                sb.check_result(got);
                moved = 1'b1;
            end
            if (moved) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_MAX) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // The receiver: random stalls by phase, plus one long hold-off on request
    // so that the pipeline fills up and pushes back on its input.
    initial begin
        int held;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                for (held = 0; held < HOLD_LEN; held++) begin
                    out_ch.ready <= 1'b0;
                    @(negedge i_clk);
                end
                hold_output = 1'b0;
            end
            case (idle_phase)
                0: out_ch.ready <= ($urandom_range(0, 99) >= 53);
                1: out_ch.ready <= ($urandom_range(0, 99) >= 34);
                default: out_ch.ready <= 1'b1;
            endcase
        end
    end

    // Offers one item: optional idle cycles, then valid held until accepted.
    task send_reading(bit cmd, logic [RAW_W-1:0] ox, logic [RAW_W-1:0] red,
                      logic [RAW_W-1:0] sup);
        int gap_pct;
        gap_pct = (idle_phase == 0) ? 34 : (idle_phase == 1) ? 53 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.ox_raw     <= ox;
        in_ch.red_raw    <= red;
        in_ch.supply_raw <= sup;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // A calibration whose references come out at the given signed values.
    task calibrate_to(int ref_ox, int ref_red);
        logic [RAW_W-1:0] sup;
        sup = RAW_W'($urandom);
        send_reading(CMD_CALIBRATE, sup - RAW_W'(ref_ox), sup - RAW_W'(ref_red), sup);
    endtask

    // A measurement aimed at a ratio given in thousandths of each reference.
    task measure_at(int red_milli, int ox_milli);
        logic [RAW_W-1:0] sup;
        longint rr, ro;
        rr = sb.cal_red[RAW_W-1] ? longint'(sb.cal_red) - 65536 : longint'(sb.cal_red);
        ro = sb.cal_ox[RAW_W-1] ? longint'(sb.cal_ox) - 65536 : longint'(sb.cal_ox);
        sup = RAW_W'($urandom);
        send_reading(CMD_MEASURE, sup - RAW_W'(ro * ox_milli / 1000),
                     sup - RAW_W'(rr * red_milli / 1000), sup);
    endtask

    initial begin
        int n, pick, ref_o, ref_r;
        i_rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.command <= CMD_MEASURE;
        in_ch.ox_raw <= '0;
        in_ch.red_raw <= '0;
        in_ch.supply_raw <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Measuring before any calibration reports no reference.
        send_reading(CMD_MEASURE, 16'h1234, 16'h5678, 16'h9abc);
        send_reading(CMD_MEASURE, 16'hffff, 16'h0000, 16'hffff);
        // Calibrating with one reference zero still leaves no conversion.
        send_reading(CMD_CALIBRATE, 16'h1000, 16'h2000, 16'h1000);
        send_reading(CMD_MEASURE, 16'h0000, 16'h0000, 16'hffff);
        calibrate_to(20000, 20000);
        measure_at(0, 1000);
        measure_at(100, 1100);
        measure_at(279, 1099);
        measure_at(306, 1101);
        measure_at(425, 3000);
        measure_at(786, 60000);
        measure_at(800, 50);
        measure_at(1500, 500);
        measure_at(-2000, -2000);
        // Tiny references drive both ratios into saturation.
        calibrate_to(1, -1);
        send_reading(CMD_MEASURE, 16'h0000, 16'h0000, 16'hffff);
        send_reading(CMD_MEASURE, 16'hffff, 16'hffff, 16'h0000);
        calibrate_to(-32768, 32767);
        send_reading(CMD_MEASURE, 16'h0000, 16'hffff, 16'hffff);
        send_reading(CMD_MEASURE, 16'hffff, 16'h0000, 16'h0000);
        calibrate_to(-300, -5000);
        measure_at(200, 2000);
        measure_at(500, 1200);
        calibrate_to(4000, 30000);

        // Random part: mostly measurements steered into the interesting ratio
        // range, with occasional recalibration and fully random readings.
        for (n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) idle_phase = 1;
            if (n == 2 * N_RANDOM / 3) idle_phase = 2;
            if (n == N_RANDOM / 2) begin
                // Withdraw the last item so it is not taken again while waiting.
                in_ch.valid <= 1'b0;
                while (sb.pending() != 0) @(negedge i_clk);
            end
            if (n == 3 * N_RANDOM / 4) hold_output = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                ref_o = $urandom_range(0, 3) == 0 ? $urandom_range(1, 200)
                                                   : $urandom_range(1000, 32767);
                ref_r = $urandom_range(0, 3) == 0 ? $urandom_range(1, 200)
                                                   : $urandom_range(1000, 32767);
                if ($urandom_range(0, 4) == 0) ref_o = -ref_o;
                if ($urandom_range(0, 9) == 0) ref_r = 0;
                calibrate_to(ref_o, ref_r);
            end else if (pick < 7) begin
                send_reading(CMD_CALIBRATE, RAW_W'($urandom), RAW_W'($urandom),
                             RAW_W'($urandom));
            end else if (pick < 20) begin
                send_reading(CMD_MEASURE, RAW_W'($urandom), RAW_W'($urandom),
                             RAW_W'($urandom));
            end else begin
                measure_at($urandom_range(0, 1000), $urandom_range(900, 8000));
            end
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
